### rtl/core/hkit_pkg.sv
// ----------------------------------------------------------------------------
// hkit_pkg: shared types and constants of the hashed key index table
// Status codes, slot states, FNV-1a 64 constants and the probe request.
// ----------------------------------------------------------------------------
`default_nettype none

package hkit_pkg;

    localparam int SLOT_COUNT    = 64;
    localparam int KEY_BYTES_MAX = 32;
    // key length counter and slot index widths
    localparam int KW = $clog2(KEY_BYTES_MAX + 1);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME   = 64'h00000100000001b3;
    localparam logic [7:0]  PAYLOAD_HDR = 8'd7;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_LIVE  = 2'd1,
        SLOT_TOMB  = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BUF_SMALL = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_PUT    = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_ALT    = 2'd3
    } mode_t;

    localparam logic [0:0] CFG_MAX_VALUE_LEN = 1'b0;
    localparam logic [0:0] CFG_HEADER_LEN    = 1'b1;

    // Probe request handed from the key collector to the table engine.
    typedef struct packed {
        logic [1:0]  mode;
        logic        too_long;
        logic [63:0] hash;
        logic [31:0] value_len;
        logic [47:0] record_offset;
        logic [31:0] buffer_capacity;
    } probe_req_t;

endpackage

`default_nettype wire

### rtl/core/hkit_key_collect.sv
// ----------------------------------------------------------------------------
// hkit_key_collect: key byte collector and FNV-1a 64 hasher
// Stores key bytes, folds them into the hash and closes a key on last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hkit_key_collect
    import hkit_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic [1:0]           mode,
    input  wire logic [7:0]           key_byte,
    input  wire logic                 key_last,
    input  wire logic [31:0]          value_len,
    input  wire logic [47:0]          record_offset,
    input  wire logic [31:0]          buffer_capacity,
    input  wire logic [KW-1:0]        key_rd_addr,
    output logic      [7:0]           key_rd_data,
    output logic                      req_valid,
    output probe_req_t                req,
    output logic      [KW-1:0]        key_len
);

    localparam int IW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;

    logic [7:0]    key_mem [KEY_BYTES_MAX];
    logic [63:0]   hash_reg, hash_next;
    logic [KW-1:0] len_reg, len_next;
    logic          long_reg, long_next;
    logic [1:0]    mode_reg, mode_next;
    logic          done_reg;
    logic [63:0]   mixed;

    assign mixed     = hash_reg ^ {56'd0, key_byte};
    // times 0x100000001b3: 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
    assign hash_next = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                       + (mixed << 4) + (mixed << 1) + mixed;
    assign mode_next = (len_reg == '0 && !long_reg) ? mode : mode_reg;
    assign len_next  = (len_reg < KW'(KEY_BYTES_MAX)) ? len_reg + 1'b1 : len_reg;
    assign long_next = long_reg || (len_reg >= KW'(KEY_BYTES_MAX));

    always_ff @(posedge clk)
    begin
        if (in_fire && len_reg < KW'(KEY_BYTES_MAX))
            key_mem[len_reg[IW-1:0]] <= key_byte;
        key_rd_data <= key_mem[key_rd_addr[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
            len_reg  <= '0;
            long_reg <= 1'b0;
            mode_reg <= MODE_PUT;
            done_reg <= 1'b0;
            key_len  <= '0;
            req      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (in_fire)
            begin
                if (key_last)
                begin
                    hash_reg     <= FNV_BASIS;
                    len_reg      <= '0;
                    long_reg     <= 1'b0;
                    done_reg     <= 1'b1;
                    key_len      <= len_next;
                    req.mode     <= mode_next;
                    req.too_long <= long_next;
                    req.hash     <= hash_next;
                    req.value_len       <= value_len;
                    req.record_offset   <= record_offset;
                    req.buffer_capacity <= buffer_capacity;
                end
                else
                begin
                    hash_reg <= hash_next;
                    len_reg  <= len_next;
                    long_reg <= long_next;
                    mode_reg <= mode_next;
                end
            end
        end
    end

    assign req_valid = done_reg;

endmodule

`default_nettype wire

### rtl/core/hkit_table_engine.sv
// ----------------------------------------------------------------------------
// hkit_table_engine: slot store and linear probe sequencer
// Walks slots from hash mod slot count, compares keys byte by byte, writes.
// ----------------------------------------------------------------------------
`default_nettype none

module hkit_table_engine
    import hkit_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  probe_req_t            req,
    input  wire logic [KW-1:0]    key_len,
    output logic      [KW-1:0]    key_rd_addr,
    input  wire logic [7:0]       key_rd_data,
    input  wire logic [15:0]      max_value_len,
    input  wire logic [7:0]       record_header_len,
    output logic                  busy,
    output logic                  res_valid,
    input  wire logic             res_taken,
    output logic [2:0]            status,
    output logic [5:0]            slot_index,
    output logic                  inserted_new,
    output logic [47:0]           value_offset,
    output logic [31:0]           value_length,
    output logic [6:0]            live_count
);

    localparam int IW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int AW = SW + IW;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_CLEAR = 8'b00000010,
        S_READ  = 8'b00000100,
        S_EVAL  = 8'b00001000,
        S_KREAD = 8'b00010000,
        S_KCMP  = 8'b00100000,
        S_WRITE = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    // Slot memories; status has its own memory so reset can sweep it.
    logic [1:0]    st_mem   [SLOT_COUNT];
    logic [63:0]   hash_mem [SLOT_COUNT];
    logic [KW-1:0] klen_mem [SLOT_COUNT];
    logic [47:0]   voff_mem [SLOT_COUNT];
    logic [31:0]   vlen_mem [SLOT_COUNT];
    logic [7:0]    key_mem  [SLOT_COUNT * KEY_BYTES_MAX];

    state_t        state_reg;
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] step_reg;
    logic [KW-1:0] kidx_reg;
    logic [KW-1:0] wr_idx_reg;
    logic          free_vld_reg;
    logic [SW-1:0] free_reg;
    logic [CW-1:0] live_reg;
    logic [SW-1:0] clr_reg;
    logic          resv_reg;

    // result under construction; copied to the outputs on hand-off
    logic [2:0]    res_status_reg;
    logic [5:0]    res_slot_reg;
    logic          res_new_reg;
    logic [47:0]   res_voff_reg;
    logic [31:0]   res_vlen_reg;

    logic [1:0]    rd_st;
    logic [63:0]   rd_hash;
    logic [KW-1:0] rd_klen;
    logic [47:0]   rd_voff;
    logic [31:0]   rd_vlen;
    logic [7:0]    rd_key;

    logic [SW-1:0] slot_next;
    logic          st_we;
    logic [1:0]    st_wd;
    logic [SW-1:0] st_wa;
    logic [SW-1:0] start_slot;

    assign start_slot = SW'(req.hash % 64'(SLOT_COUNT));
    assign slot_next  = (slot_reg == SW'(SLOT_COUNT - 1)) ? '0 : slot_reg + 1'b1;
    assign key_rd_addr = (state_reg == S_WRITE) ? wr_idx_reg : kidx_reg;

    always_ff @(posedge clk)
    begin
        rd_st   <= st_mem[slot_reg];
        rd_hash <= hash_mem[slot_reg];
        rd_klen <= klen_mem[slot_reg];
        rd_voff <= voff_mem[slot_reg];
        rd_vlen <= vlen_mem[slot_reg];
        rd_key  <= key_mem[{slot_reg, kidx_reg[IW-1:0]}];
        if (st_we)
            st_mem[st_wa] <= st_wd;
        if (state_reg == S_WRITE && wr_idx_reg == '0)
        begin
            hash_mem[slot_reg] <= req.hash;
            klen_mem[slot_reg] <= key_len;
            voff_mem[slot_reg] <= req.record_offset + 48'(record_header_len)
                                  + 48'(PAYLOAD_HDR) + 48'(key_len);
            vlen_mem[slot_reg] <= req.value_len;
        end
        // key read data is registered, so each byte is written one index behind the read address
        if (state_reg == S_WRITE && wr_idx_reg != '0)
            key_mem[AW'({slot_reg, IW'(wr_idx_reg - 1'b1)})] <= key_rd_data;
    end

    always_comb
    begin
        st_we = 1'b0;
        st_wd = SLOT_EMPTY;
        st_wa = slot_reg;
        if (state_reg == S_CLEAR)
        begin
            st_we = 1'b1;
            st_wa = clr_reg;
        end
        else if (state_reg == S_WRITE && wr_idx_reg == key_len)
        begin
            st_we = 1'b1;
            st_wd = (req.mode == MODE_DELETE) ? SLOT_TOMB : SLOT_LIVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            slot_reg       <= '0;
            step_reg       <= '0;
            kidx_reg       <= '0;
            wr_idx_reg     <= '0;
            free_vld_reg   <= 1'b0;
            free_reg       <= '0;
            live_reg       <= '0;
            clr_reg        <= '0;
            resv_reg       <= 1'b0;
            res_status_reg <= ST_OK;
            res_slot_reg   <= '0;
            res_new_reg    <= 1'b0;
            res_voff_reg   <= '0;
            res_vlen_reg   <= '0;
            res_valid      <= 1'b0;
            status         <= ST_OK;
            slot_index     <= '0;
            inserted_new   <= 1'b0;
            value_offset   <= '0;
            value_length   <= '0;
            live_count     <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SW'(SLOT_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        res_status_reg <= ST_OK;
                        res_slot_reg   <= '0;
                        res_new_reg    <= 1'b0;
                        res_voff_reg   <= '0;
                        res_vlen_reg   <= '0;
                        slot_reg       <= start_slot;
                        step_reg       <= '0;
                        kidx_reg       <= '0;
                        free_vld_reg   <= 1'b0;
                        resv_reg       <= 1'b0;
                        if (req.too_long)
                        begin
                            res_status_reg <= (req.mode == MODE_PUT) ? ST_BAD_LEN
                                                                     : ST_NOT_FOUND;
                            state_reg      <= S_DONE;
                        end
                        else if (req.mode == MODE_PUT &&
                                 req.value_len > 32'(max_value_len))
                        begin
                            res_status_reg <= ST_BAD_LEN;
                            state_reg      <= S_DONE;
                        end
                        else
                            state_reg <= S_READ;
                    end
                end
                S_READ:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (step_reg == CW'(SLOT_COUNT) || rd_st == SLOT_EMPTY)
                    begin
                        if (req.mode != MODE_PUT)
                        begin
                            res_status_reg <= ST_NOT_FOUND;
                            state_reg      <= S_DONE;
                        end
                        else if (free_vld_reg)
                        begin
                            slot_reg   <= free_reg;
                            resv_reg   <= 1'b1;
                            wr_idx_reg <= '0;
                            state_reg  <= S_WRITE;
                        end
                        else if (step_reg != CW'(SLOT_COUNT))
                        begin
                            resv_reg   <= 1'b1;
                            wr_idx_reg <= '0;
                            state_reg  <= S_WRITE;
                        end
                        else
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_DONE;
                        end
                    end
                    else if (rd_st == SLOT_LIVE && rd_hash == req.hash &&
                             rd_klen == key_len)
                    begin
                        kidx_reg  <= '0;
                        state_reg <= S_KREAD;
                    end
                    else
                    begin
                        if (rd_st != SLOT_LIVE && !free_vld_reg)
                        begin
                            free_vld_reg <= 1'b1;
                            free_reg     <= slot_reg;
                        end
                        slot_reg  <= slot_next;
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_KREAD:
                begin
                    if (kidx_reg == key_len)
                    begin
                        // full match
                        kidx_reg <= '0;
                        if (req.mode == MODE_PUT)
                        begin
                            wr_idx_reg <= '0;
                            state_reg  <= S_WRITE;
                        end
                        else if (req.mode == MODE_DELETE)
                        begin
                            res_slot_reg <= 6'(slot_reg);
                            wr_idx_reg   <= key_len;
                            state_reg    <= S_WRITE;
                        end
                        else if (rd_vlen > req.buffer_capacity)
                        begin
                            res_status_reg <= ST_BUF_SMALL;
                            res_vlen_reg   <= rd_vlen;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            res_slot_reg <= 6'(slot_reg);
                            res_voff_reg <= rd_voff;
                            res_vlen_reg <= rd_vlen;
                            state_reg    <= S_DONE;
                        end
                    end
                    else
                        state_reg <= S_KCMP;
                end
                S_KCMP:
                begin
                    if (rd_key == key_rd_data)
                    begin
                        kidx_reg  <= kidx_reg + 1'b1;
                        state_reg <= S_KREAD;
                    end
                    else
                    begin
                        kidx_reg  <= '0;
                        slot_reg  <= slot_next;
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_WRITE:
                begin
                    if (wr_idx_reg == key_len)
                    begin
                        if (req.mode == MODE_DELETE)
                        begin
                            if (live_reg != '0)
                                live_reg <= live_reg - 1'b1;
                        end
                        else
                        begin
                            if (resv_reg)
                                live_reg <= live_reg + 1'b1;
                            res_slot_reg <= 6'(slot_reg);
                            res_new_reg  <= resv_reg;
                            res_voff_reg <= req.record_offset + 48'(record_header_len)
                                            + 48'(PAYLOAD_HDR) + 48'(key_len);
                            res_vlen_reg <= req.value_len;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                        wr_idx_reg <= wr_idx_reg + 1'b1;
                end
                S_DONE:
                begin
                    // hand off once the output register is free
                    if (!res_valid || res_taken)
                    begin
                        res_valid    <= 1'b1;
                        status       <= res_status_reg;
                        slot_index   <= res_slot_reg;
                        inserted_new <= res_new_reg;
                        value_offset <= res_voff_reg;
                        value_length <= res_vlen_reg;
                        live_count   <= 7'(live_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            if (res_valid && res_taken && state_reg != S_DONE)
                res_valid <= 1'b0;
        end
    end

    assign busy = (state_reg != S_IDLE) || req_valid;

endmodule

`default_nettype wire

### rtl/core/hashed_key_index_table.sv
// ----------------------------------------------------------------------------
// hashed_key_index_table: hashed key index with linear probing
// FNV-1a 64 keyed open addressing table over on-chip slot memories.
// ----------------------------------------------------------------------------
// channel  direction  handshake         beat
// in       sink       in_valid/stall    one key byte plus operation fields
// out      source     out_valid/stall   one result on each last key byte
// cfg      sink       cfg_valid/ready   register index and write data
//
// Key bytes are taken while in_stall is low. After a last byte in_stall stays
// high until the probe engine is idle again: it starts, reads each slot
// visited, compares key bytes, writes a put's key and state or a delete's
// tombstone, and hands off. Reset sweeps the slot status memory with in_stall
// high. The result sits in an output register; the next key is taken while it
// waits, but the engine holds its next result until out_stall clears.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_key_index_table
    import hkit_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  key_byte,
    input  wire logic        key_last,
    input  wire logic [31:0] value_len,
    input  wire logic [47:0] record_offset,
    input  wire logic [31:0] buffer_capacity,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [5:0]       slot_index,
    output logic             inserted_new,
    output logic [47:0]      value_offset,
    output logic [31:0]      value_length,
    output logic [6:0]       live_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0]   max_len_reg;
    logic [7:0]    hdr_len_reg;
    logic          in_fire;
    logic          busy;
    logic          req_valid;
    probe_req_t    req;
    logic [KW-1:0] key_len;
    logic [KW-1:0] key_rd_addr;
    logic [7:0]    key_rd_data;

    // the engine reads the collected key, so bytes wait until it is free
    assign in_stall  = busy;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 16'd256;
            hdr_len_reg <= 8'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_VALUE_LEN: max_len_reg <= cfg_data;
                CFG_HEADER_LEN:    hdr_len_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    hkit_key_collect u_collect (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_fire         (in_fire),
        .mode            (mode),
        .key_byte        (key_byte),
        .key_last        (key_last),
        .value_len       (value_len),
        .record_offset   (record_offset),
        .buffer_capacity (buffer_capacity),
        .key_rd_addr     (key_rd_addr),
        .key_rd_data     (key_rd_data),
        .req_valid       (req_valid),
        .req             (req),
        .key_len         (key_len)
    );

    hkit_table_engine u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req               (req),
        .key_len           (key_len),
        .key_rd_addr       (key_rd_addr),
        .key_rd_data       (key_rd_data),
        .max_value_len     (max_len_reg),
        .record_header_len (hdr_len_reg),
        .busy              (busy),
        .res_valid         (out_valid),
        .res_taken         (!out_stall),
        .status            (status),
        .slot_index        (slot_index),
        .inserted_new      (inserted_new),
        .value_offset      (value_offset),
        .value_length      (value_length),
        .live_count        (live_count)
    );

endmodule

`default_nettype wire

### tb/tb_hashed_key_index_table.sv
// ----------------------------------------------------------------------------
// tb_hashed_key_index_table: self-checking bench for the hashed key index
// Sends keys byte by byte with put, delete, lookup and alt operations,
// keeps a shadow probe table with its own FNV-1a 64 hashing, and checks each
// result beat field by field. Inputs idle and outputs stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hashed_key_index_table;
    timeunit 1ns;
    timeprecision 1ps;
    import hkit_pkg::*;

    localparam int SLOTS      = 64;
    localparam int KEY_MAX    = 32;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 300;
    localparam int BEAT_GOAL  = 1600;

    typedef logic [7:0] key_q_t[$];

    typedef struct {
        status_t     status;
        logic [5:0]  slot;
        logic        fresh;
        logic [47:0] voff;
        logic [31:0] vlen;
        logic [6:0]  live;
    } index_result_t;

    // ------------------------------------------------------------------
    // Shadow of the slot table and the expected result beats
    // ------------------------------------------------------------------
    class index_scoreboard;
        slot_state_t   st[SLOTS];
        logic [63:0]   hsh[SLOTS];
        int            klen[SLOTS];
        logic [7:0]    kst[SLOTS][KEY_MAX];
        logic [47:0]   voffs[SLOTS];
        logic [31:0]   vlens[SLOTS];
        logic [7:0]    ikey[KEY_MAX];
        logic [63:0]   rh;
        int            ilen;
        bit            too_long;
        int            live;
        logic [1:0]    pmode;
        logic [15:0]   max_vlen;
        logic [7:0]    hdr_len;
        index_result_t awaited[$];
        int            errors;
        int            hist[5];

        function new();
            foreach (st[i]) st[i] = SLOT_EMPTY;
            rh       = FNV_BASIS;
            ilen     = 0;
            too_long = 0;
            live     = 0;
            pmode    = MODE_PUT;
            max_vlen = 16'd256;
            hdr_len  = 8'd16;
            errors   = 0;
            foreach (hist[i]) hist[i] = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [15:0] d);
            if (idx == CFG_MAX_VALUE_LEN) max_vlen = d;
            else hdr_len = d[7:0];
        endfunction

        function bit key_match(int s);
            if (st[s] != SLOT_LIVE || hsh[s] != rh || klen[s] != ilen) return 0;
            for (int i = 0; i < ilen; i++)
                if (kst[s][i] != ikey[i]) return 0;
            return 1;
        endfunction

        function void note_beat(logic [1:0] m, logic [7:0] b, bit last,
                                logic [31:0] vl, logic [47:0] ro, logic [31:0] cap);
            index_result_t r;
            int s;
            int spare_slot;
            int t;
            bit fresh;
            bit done;
            if (ilen == 0 && !too_long) pmode = m;
            rh = (rh ^ {56'd0, b}) * FNV_PRIME;
            if (ilen < KEY_MAX) begin
                ikey[ilen] = b;
                ilen++;
            end
            else too_long = 1;
            if (!last) return;

            r.status = ST_OK;
            r.slot = '0; r.fresh = 0; r.voff = '0; r.vlen = '0;
            s = -1;
            if (pmode == MODE_PUT) begin
                if (too_long || vl > {16'd0, max_vlen}) r.status = ST_BAD_LEN;
                else begin
                    spare_slot = -1;
                    fresh = 1;
                    done = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        t = (int'(rh[5:0]) + i) % SLOTS;
                        if (st[t] == SLOT_LIVE) begin
                            if (key_match(t)) begin
                                fresh = 0; s = t; done = 1;
                                break;
                            end
                        end
                        else if (st[t] == SLOT_EMPTY) begin
                            s = (spare_slot >= 0) ? spare_slot : t;
                            done = 1;
                            break;
                        end
                        else if (spare_slot < 0) spare_slot = t;
                    end
                    if (!done) s = spare_slot;
                    if (s < 0) r.status = ST_FULL;
                    else begin
                        if (st[s] != SLOT_LIVE) live++;
                        st[s] = SLOT_LIVE;
                        hsh[s] = rh;
                        klen[s] = ilen;
                        for (int i = 0; i < ilen; i++) kst[s][i] = ikey[i];
                        voffs[s] = ro + 48'(hdr_len) + 48'(PAYLOAD_HDR) + 48'(ilen);
                        vlens[s] = vl;
                        r.slot = s[5:0]; r.fresh = fresh;
                        r.voff = voffs[s]; r.vlen = vl;
                    end
                end
            end
            else begin
                if (!too_long)
                    for (int i = 0; i < SLOTS; i++) begin
                        t = (int'(rh[5:0]) + i) % SLOTS;
                        if (st[t] == SLOT_EMPTY) break;
                        if (key_match(t)) begin
                            s = t;
                            break;
                        end
                    end
                if (s < 0) r.status = ST_NOT_FOUND;
                else if (pmode == MODE_DELETE) begin
                    st[s] = SLOT_TOMB;
                    if (live > 0) live--;
                    r.slot = s[5:0];
                end
                else if (vlens[s] > cap) begin
                    r.status = ST_BUF_SMALL;
                    r.vlen = vlens[s];
                end
                else begin
                    r.slot = s[5:0]; r.voff = voffs[s]; r.vlen = vlens[s];
                end
            end
            r.live = live[6:0];
            awaited.push_back(r);
            rh = FNV_BASIS;
            ilen = 0;
            too_long = 0;
        endfunction

        function void check_result(logic [2:0] stat, logic [5:0] slot, logic fresh,
                                   logic [47:0] voff, logic [31:0] vlen, logic [6:0] lc);
            index_result_t e;
            if (awaited.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            e = awaited.pop_front();
            hist[e.status]++;
            if (stat !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, stat); errors++;
            end
            if (slot !== e.slot) begin
                $error("slot_index: expected %0d, got %0d", e.slot, slot); errors++;
            end
            if (fresh !== e.fresh) begin
                $error("inserted_new: expected %0d, got %0d", e.fresh, fresh); errors++;
            end
            if (voff !== e.voff) begin
                $error("value_offset: expected %h, got %h", e.voff, voff); errors++;
            end
            if (vlen !== e.vlen) begin
                $error("value_length: expected %h, got %h", e.vlen, vlen); errors++;
            end
            if (lc !== e.live) begin
                $error("live_count: expected %0d, got %0d", e.live, lc); errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  mode = '0;
    logic [7:0]  key_byte = '0;
    logic        key_last = 0;
    logic [31:0] value_len = '0;
    logic [47:0] record_offset = '0;
    logic [31:0] buffer_capacity = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic        inserted_new;
    logic [47:0] value_offset;
    logic [31:0] value_length;
    logic [6:0]  live_count;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    index_scoreboard sb = new();
    bit      calm = 0;
    int      beats = 0;
    int      idle_cycles = 0;
    int      stall_hold = 0;
    key_q_t  pool[96];

    hashed_key_index_table i_dut (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // result side: stall runs of random length
    always @(posedge clk) begin
        if (stall_hold > 0) stall_hold--;
        else begin
            out_stall  <= !calm && ($urandom_range(0, 2) == 0);
            stall_hold = pick_gap();
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, slot_index, inserted_new, value_offset,
                            value_length, live_count);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_beat(logic [1:0] m, logic [7:0] b, bit last,
                             logic [31:0] vl, logic [47:0] ro, logic [31:0] cap);
        int g;
        g = pick_gap();
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid        <= 1;
        mode            <= m;
        key_byte        <= b;
        key_last        <= last;
        value_len       <= vl;
        record_offset   <= ro;
        buffer_capacity <= cap;
        do @(posedge clk); while (in_stall);
        sb.note_beat(m, b, last, vl, ro, cap);
        beats++;
    endtask

    // mode is only read on the first byte, operands only on the last
    task automatic send_key(logic [1:0] m, key_q_t k, logic [31:0] vl,
                            logic [47:0] ro, logic [31:0] cap);
        bit last;
        for (int i = 0; i < k.size(); i++) begin
            last = (i == k.size() - 1);
            send_beat((i == 0) ? m : 2'($urandom), k[i], last,
                      last ? vl : $urandom, last ? ro : rand48(),
                      last ? cap : $urandom);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(logic [0:0] idx, logic [15:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    function automatic key_q_t make_key(int len);
        key_q_t k;
        for (int i = 0; i < len; i++) k.push_back(8'($urandom));
        return k;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 4);
        if (r < 93) return $urandom_range(5, 32);
        return $urandom_range(33, 40);
    endfunction

    task automatic random_op();
        key_q_t      k;
        logic [1:0]  m;
        logic [31:0] vl;
        logic [31:0] cap;
        int          r;
        if ($urandom_range(0, 9) == 0) k = make_key(pick_len());
        else k = pool[$urandom_range(0, 95)];
        r = $urandom_range(0, 99);
        if (r < 50) m = MODE_PUT;
        else if (r < 70) m = MODE_DELETE;
        else if (r < 94) m = MODE_LOOKUP;
        else m = MODE_ALT;
        vl  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, sb.max_vlen) : $urandom;
        r   = $urandom_range(0, 9);
        cap = (r < 4) ? $urandom_range(0, sb.max_vlen) : (r < 9) ? 32'hFFFF_FFFF : $urandom;
        send_key(m, k, vl, rand48(), cap);
    endtask

    initial begin
        key_q_t ka;
        key_q_t kb;
        int     goal;
        bit     paused;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (pool[i]) pool[i] = make_key(pick_len());
        ka = '{8'h00};
        kb = '{8'hFF, 8'h00, 8'hA5};
        paused = 0;

        // directed: insert, update, length limits, buffer check, delete, misses
        send_key(MODE_PUT, ka, 32'd0, 48'd0, 32'd0);
        send_key(MODE_PUT, ka, 32'd256, 48'hFFFF_FFFF_FFFF, 32'd0);
        send_key(MODE_PUT, kb, 32'd257, rand48(), 32'd0);
        send_key(MODE_PUT, kb, 32'hFFFF_FFFF, rand48(), 32'd0);
        send_key(MODE_PUT, kb, 32'd1, rand48(), 32'd0);
        send_key(MODE_LOOKUP, ka, 32'd0, 48'd0, 32'd255);
        send_key(MODE_LOOKUP, ka, 32'd0, 48'd0, 32'hFFFF_FFFF);
        send_key(MODE_ALT, kb, 32'd0, 48'd0, 32'd1);
        send_key(MODE_DELETE, ka, 32'd0, 48'd0, 32'd0);
        send_key(MODE_DELETE, ka, 32'd0, 48'd0, 32'd0);
        send_key(MODE_LOOKUP, ka, 32'd0, 48'd0, 32'hFFFF_FFFF);
        send_key(MODE_PUT, ka, 32'd5, rand48(), 32'd0);
        send_key(MODE_PUT, make_key(KEY_MAX + 1), 32'd1, rand48(), 32'd0);

        // register phases: extremes first, then random settings
        for (int p = 0; p < 6; p++) begin
            drain();
            repeat (SETTLE) @(posedge clk);
            case (p)
                0: begin cfg_write(CFG_MAX_VALUE_LEN, 16'd0);     cfg_write(CFG_HEADER_LEN, 16'd0); end
                1: begin cfg_write(CFG_MAX_VALUE_LEN, 16'hFFFF);  cfg_write(CFG_HEADER_LEN, 16'hFFFF); end
                default: begin
                    cfg_write(CFG_MAX_VALUE_LEN, 16'($urandom));
                    cfg_write(CFG_HEADER_LEN, 16'($urandom));
                end
            endcase
            calm = (p == 3);
            goal = beats + BEAT_GOAL / 6;
            while (beats < goal) begin
                random_op();
                if (p == 2 && !paused && beats > goal - BEAT_GOAL / 12) begin
                    drain();   // hold the sender until every result is back
                    paused = 1;
                end
            end
        end
        calm = 0;
        drain();
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d key beats over 7 register settings", beats);
        $display("results: ok %0d, not found %0d, full %0d, bad length %0d, buffer %0d",
                 sb.hist[0], sb.hist[1], sb.hist[2], sb.hist[3], sb.hist[4]);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
